FILE: hdl/lef_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

  typedef logic [7:0] chan_t;
  // index 2 = red, 1 = green, 0 = blue
  typedef logic [2:0][7:0] pix_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FW_FIELD_W = 11;
  localparam int FH_W       = 16;
  localparam int MIN_DIM    = 3;
  localparam int NSUM_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/lef_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lef_pix_if;
  logic          valid;
  logic          ready;
  logic          req_type;
  lef_pkg::chan_t red_in;
  lef_pkg::chan_t green_in;
  lef_pkg::chan_t blue_in;

  modport source (output valid, output req_type, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input req_type, input red_in, input green_in,
                input blue_in, output ready);
endinterface

`default_nettype wire

FILE: hdl/lef_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lef_res_if;
  logic          valid;
  logic          ready;
  lef_pkg::chan_t red_out;
  lef_pkg::chan_t green_out;
  lef_pkg::chan_t blue_out;
  logic          end_of_frame;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output end_of_frame, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input end_of_frame, output ready);
endinterface

`default_nettype wire

FILE: hdl/rgb_laplacian_edge_filter_core.sv
// A result moves through stages s1, s2, s3 and the output register after the transfer that causes it.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// The line memory (two lines packed per word) is read at transfer and written at stage s1.
// Reset: frame size returns to 640 x 480, all counters and valid flags clear.
// Line memory contents are not cleared; stale words only reach border results.
`timescale 1ns / 1ps
`default_nettype none

module rgb_laplacian_edge_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lef_pix_if.sink                             in_if,
  lef_res_if.source                           out_if,
  input  wire logic                           cfg_we,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [lef_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int WX = WW + 1;
  localparam int HW = lef_pkg::FH_W;
  localparam int SW = lef_pkg::NSUM_W;

  logic [WW-1:0] frame_width_r;
  logic [HW-1:0] frame_height_r;
  logic [AW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;

  logic          adv, acc;
  logic [AW-1:0] rd_addr;
  logic          emit, eof, interior, is_flush;

  // pipeline
  logic          s1_vld_r, s1_pix_r, s1_emit_r, s1_zero_r, s1_eof_r;
  lef_pkg::pix_t s1_px_r;
  logic [AW-1:0] s1_addr_r;
  logic [47:0]   rd_r;
  logic          s2_vld_r, s2_zero_r, s2_eof_r;
  logic          s3_vld_r, s3_zero_r, s3_eof_r;
  logic [2:0][SW-1:0] s3_nsum_r;
  lef_pkg::pix_t s3_ctr_r;
  logic          out_vld_r, out_eof_r;
  lef_pkg::pix_t out_px_r;

  lef_pkg::pix_t window_r [3][3];
  logic [47:0]   mem [MAX_WIDTH];

  logic [2:0][SW-1:0] nsum;
  lef_pkg::pix_t      res;

  logic [lef_pkg::FW_FIELD_W-1:0] cfg_w;
  logic [WW-1:0]                  cfg_w_sat;
  logic [HW-1:0]                  cfg_h_sat;

  assign adv          = !out_vld_r || out_if.ready;
  assign in_if.ready  = adv;
  assign acc          = adv && in_if.valid;
  assign is_flush     = in_if.req_type == lef_pkg::REQ_FLUSH;

  // frame position bookkeeping for one transfer
  always_comb begin
    logic          done;
    logic [AW-1:0] acol, ocol;
    logic [HW-1:0] arow, orow;
    done        = in_row_r >= frame_height_r;
    acol        = in_col_r;
    arow        = in_row_r;
    ocol        = out_col_r;
    orow        = out_row_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    emit        = 1'b0;
    eof         = 1'b0;
    if (is_flush) begin
      emit = done;
    end else begin
      if (done) begin
        acol = '0;
        arow = '0;
        ocol = '0;
        orow = '0;
      end
      emit = (arow >= HW'(2)) || (arow == HW'(1) && acol != '0);
      if ((WW'(acol) + WW'(1)) >= frame_width_r) begin
        in_col_nxt = '0;
        in_row_nxt = arow + HW'(1);
      end else begin
        in_col_nxt = acol + AW'(1);
        in_row_nxt = arow;
      end
    end
    rd_addr  = acol;
    interior = orow != '0 && ((HW + 1)'(orow) + (HW + 1)'(2)) <= (HW + 1)'(frame_height_r) &&
               ocol != '0 && (WX'(ocol) + WX'(2)) <= WX'(frame_width_r);
    out_col_nxt = ocol;
    out_row_nxt = orow;
    if (emit) begin
      if ((WW'(ocol) + WW'(1)) >= frame_width_r) begin
        out_col_nxt = '0;
        out_row_nxt = orow + HW'(1);
        if ((orow + HW'(1)) >= frame_height_r) begin
          eof         = 1'b1;
          out_row_nxt = '0;
          in_col_nxt  = '0;
          in_row_nxt  = '0;
        end
      end else begin
        out_col_nxt = ocol + AW'(1);
      end
    end
  end

  always_comb begin
    cfg_w = cfg_wdata[lef_pkg::FW_FIELD_W-1:0];
    if (32'(cfg_w) < lef_pkg::MIN_DIM) begin
      cfg_w_sat = WW'(lef_pkg::MIN_DIM);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      cfg_w_sat = WW'(MAX_WIDTH);
    end else begin
      cfg_w_sat = WW'(cfg_w);
    end
    if (32'(cfg_wdata) < lef_pkg::MIN_DIM) begin
      cfg_h_sat = HW'(lef_pkg::MIN_DIM);
    end else begin
      cfg_h_sat = cfg_wdata[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WW'(640);
      frame_height_r <= HW'(480);
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lef_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_w_sat;
        lef_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_h_sat;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_if.valid;
      s2_vld_r  <= s1_vld_r && s1_emit_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // line memory: word = {two lines back, previous line}
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mem[rd_addr];
      if (s1_vld_r && s1_pix_r) begin
        mem[s1_addr_r] <= {rd_r[23:0], s1_px_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r  <= !is_flush;
      s1_emit_r <= emit;
      s1_zero_r <= is_flush || !interior;
      s1_eof_r  <= eof;
      s1_px_r   <= {in_if.red_in, in_if.green_in, in_if.blue_in};
      s1_addr_r <= rd_addr;
      if (s1_vld_r && s1_pix_r) begin
        for (int r = 0; r < 3; r++) begin
          window_r[r][0] <= window_r[r][1];
          window_r[r][1] <= window_r[r][2];
        end
        window_r[0][2] <= rd_r[47:24];
        window_r[1][2] <= rd_r[23:0];
        window_r[2][2] <= s1_px_r;
      end
      s2_zero_r <= s1_zero_r;
      s2_eof_r  <= s1_eof_r;
      s3_zero_r <= s2_zero_r;
      s3_eof_r  <= s2_eof_r;
      s3_nsum_r <= nsum;
      s3_ctr_r  <= window_r[1][1];
      out_eof_r <= s3_eof_r;
      out_px_r  <= s3_zero_r ? '0 : res;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      nsum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (r != 1 || c != 1) begin
            nsum[ch] = nsum[ch] + SW'(window_r[r][c][ch]);
          end
        end
      end
    end
  end

  always_comb begin
    logic signed [SW:0] diff;
    diff = '0;
    for (int ch = 0; ch < 3; ch++) begin
      diff = $signed({1'b0, s3_ctr_r[ch], 3'b000}) - $signed({1'b0, s3_nsum_r[ch]});
      if (diff[SW]) begin
        res[ch] = '0;
      end else if (diff[SW-1:8] != '0) begin
        res[ch] = 8'hFF;
      end else begin
        res[ch] = diff[7:0];
      end
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.red_out      = out_px_r[2];
  assign out_if.green_out    = out_px_r[1];
  assign out_if.blue_out     = out_px_r[0];
  assign out_if.end_of_frame = out_eof_r;

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !is_flush && s1_vld_r && s1_pix_r |-> rd_addr != s1_addr_r)
    else $error("line memory read and write hit the same entry");

  a_eof_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_eof_r |-> out_px_r == '0)
    else $error("end of frame result not zero");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < frame_width_r && WW'(out_col_r) < frame_width_r)
    else $error("column counter beyond frame width");

  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !cfg_we && eof |=> in_row_r == '0 && in_col_r == '0 && out_row_r == '0)
    else $error("counters not restarted after last result");

  a_flush_no_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_flush && !emit |=> in_row_r == $past(in_row_r) || $past(cfg_we))
    else $error("ignored flush moved the input position");

endmodule

`default_nettype wire

FILE: dv/edge_checker.sv
`timescale 1ns / 1ps

module edge_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lef_pix_if                             pix,
  lef_res_if                             res,
  input  logic                           cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             queued
);

  typedef struct packed {
    lef_pkg::chan_t red;
    lef_pkg::chan_t green;
    lef_pkg::chan_t blue;
    logic           eof;
  } edge_res_t;

  edge_res_t     edge_q[$];
  lef_pkg::pix_t line_prev [MAX_WIDTH];
  lef_pkg::pix_t line_prev2 [MAX_WIDTH];
  lef_pkg::pix_t win [3][3];
  logic [10:0]   fw;
  logic [15:0]   fh;
  logic [10:0]   in_col;
  logic [10:0]   out_col;
  logic [15:0]   in_row;
  logic [15:0]   out_row;
  int            errs = 0;

  function automatic lef_pkg::chan_t laplace(int ch);
    int acc;
    acc = 8 * int'(win[1][1][ch]);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (r != 1 || c != 1) acc -= int'(win[r][c][ch]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return lef_pkg::chan_t'(acc);
  endfunction

  task automatic restart_raster();
    in_col  = '0;
    in_row  = '0;
    out_col = '0;
    out_row = '0;
  endtask

  task automatic emit_filtered();
    edge_res_t e;
    bit        interior;
    interior = out_row >= 1 && int'(out_row) + 2 <= int'(fh) &&
               out_col >= 1 && int'(out_col) + 2 <= int'(fw);
    e.red   = interior ? laplace(2) : '0;
    e.green = interior ? laplace(1) : '0;
    e.blue  = interior ? laplace(0) : '0;
    e.eof   = 1'b0;
    out_col++;
    if (out_col >= fw) begin
      out_col = '0;
      out_row++;
      if (out_row >= fh) begin
        e.eof = 1'b1;
        restart_raster();
      end
    end
    edge_q.push_back(e);
  endtask

  task automatic take_item(logic kind, lef_pkg::pix_t px);
    logic [10:0]   ic;
    lef_pkg::pix_t top;
    lef_pkg::pix_t mid;
    bit            ready;
    if (kind == lef_pkg::REQ_FLUSH) begin
      if (in_row >= fh) emit_filtered();
    end else begin
      if (in_row >= fh) restart_raster();
      ic  = (in_col < MAX_WIDTH) ? in_col : '0;
      top = line_prev2[ic];
      mid = line_prev[ic];
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      line_prev2[ic] = mid;
      line_prev[ic]  = px;
      ready = in_row >= 2 || (in_row == 1 && ic >= 1);
      in_col = ic + 1;
      if (in_col >= fw) begin
        in_col = '0;
        in_row++;
      end
      if (ready) emit_filtered();
    end
  endtask

  task automatic report_field(string field, logic [7:0] want, logic [7:0] got);
    errs++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_result(edge_res_t got);
    edge_res_t want;
    if (edge_q.size() == 0) begin
      errs++;
      $display("%0t: unexpected transfer, expected none, actual r=%0d g=%0d b=%0d eof=%0b",
               $time, got.red, got.green, got.blue, got.eof);
    end else begin
      want = edge_q.pop_front();
      if (got.red !== want.red) report_field("red_out", want.red, got.red);
      if (got.green !== want.green) report_field("green_out", want.green, got.green);
      if (got.blue !== want.blue) report_field("blue_out", want.blue, got.blue);
      if (got.eof !== want.eof) report_field("end_of_frame", 8'(want.eof), 8'(got.eof));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fw = 11'd640;
      fh = 16'd480;
      restart_raster();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      edge_q.delete();
    end else begin
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        check_result({res.red_out, res.green_out, res.blue_out, res.end_of_frame});
      end
      if (pix.valid === 1'b1 && pix.ready === 1'b1) begin
        take_item(pix.req_type, {pix.red_in, pix.green_in, pix.blue_in});
      end
      if (cfg_we) begin
        if (cfg_idx == lef_pkg::CFG_FRAME_WIDTH) begin
          fw = cfg_wdata[10:0];
          if (fw < lef_pkg::MIN_DIM) fw = 11'(lef_pkg::MIN_DIM);
          if (fw > MAX_WIDTH) fw = 11'(MAX_WIDTH);
          restart_raster();
        end else if (cfg_idx == lef_pkg::CFG_FRAME_HEIGHT) begin
          fh = cfg_wdata;
          if (fh < lef_pkg::MIN_DIM) fh = 16'(lef_pkg::MIN_DIM);
          restart_raster();
        end
      end
    end
    fail_count <= errs;
    queued     <= edge_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_PCT     = 18;
  localparam int MAX_WIDTH_TB = 1024;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lef_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           sink_ready = 1'b0;
  bit                             calm = 1'b0;
  int                             fails;
  int                             outstanding;
  int                             fed = 0;

  lef_pix_if pix ();
  lef_res_if res ();

  assign res.ready = sink_ready;

  rgb_laplacian_edge_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pix),
    .out_if    (res),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  edge_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix),
    .res        (res),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fails),
    .queued     (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic lef_pkg::chan_t rand_chan();
    int pick;
    pick = $urandom_range(5);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return lef_pkg::chan_t'($urandom_range(255));
  endfunction

  task automatic push_item(logic kind, lef_pkg::chan_t r, lef_pkg::chan_t g,
                           lef_pkg::chan_t b);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid    <= 1'b1;
    pix.req_type <= kind;
    pix.red_in   <= r;
    pix.green_in <= g;
    pix.blue_in  <= b;
    @(posedge clk);
    while (pix.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic stream_pixels(int n, int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_item(lef_pkg::REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
      end
      push_item(lef_pkg::REQ_PIXEL, rand_chan(), rand_chan(), rand_chan());
      fed++;
      calm <= fed >= 700 && fed < 1100;
    end
  endtask

  task automatic flush_n(int n);
    for (int i = 0; i < n; i++) begin
      push_item(lef_pkg::REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
      fed++;
    end
  endtask

  // hold the input until every pending result has left, then let the pipe empty
  task automatic settle();
    pix.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(logic [15:0] w_raw, logic [15:0] h_raw);
    cfg_we    <= 1'b1;
    cfg_idx   <= lef_pkg::CFG_FRAME_WIDTH;
    cfg_wdata <= w_raw;
    @(posedge clk);
    cfg_idx   <= lef_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata <= h_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int          w;
    int          h;
    bit          regeo;
    bit          partial;
    bit          center;
    logic [15:0] w_raw;
    logic [15:0] h_raw;

    pix.valid    <= 1'b0;
    pix.req_type <= lef_pkg::REQ_PIXEL;
    pix.red_in   <= '0;
    pix.green_in <= '0;
    pix.blue_in  <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= lef_pkg::CFG_FRAME_WIDTH;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // both sizes below the minimum, upper width bits ignored
    set_geometry(16'hF800, 16'h0002);
    push_item(lef_pkg::REQ_FLUSH, 8'd0, 8'd0, 8'd0);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        center = (r == 1 && c == 1);
        push_item(lef_pkg::REQ_PIXEL, center ? 8'd255 : 8'd0, center ? 8'd0 : 8'd255,
                  lef_pkg::chan_t'($urandom_range(255)));
      end
    end
    // partial drain, then a new frame abandons the rest
    flush_n(2);
    stream_pixels(9, 0);
    flush_n(4);
    push_item(lef_pkg::REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
    settle();

    set_geometry(16'd3, 16'hFFFF);
    stream_pixels(20, 15);
    settle();

    // widest line, wraps past the last memory entry
    set_geometry(16'h07FF, 16'd3);
    stream_pixels(MAX_WIDTH_TB + 8, 0);
    settle();

    regeo   = 1'b1;
    partial = 1'b0;
    w       = 3;
    h       = 3;
    while (fed < 1950) begin
      if (regeo || $urandom_range(3) == 0) begin
        settle();
        w     = $urandom_range(3, ($urandom_range(7) == 0) ? 48 : 10);
        h     = $urandom_range(3, 6);
        w_raw = {5'($urandom), 11'(w)};
        h_raw = 16'(h);
        if ($urandom_range(9) == 0) begin
          w     = 3;
          w_raw = {5'($urandom), 11'($urandom_range(2))};
        end
        if ($urandom_range(9) == 0) begin
          h     = 3;
          h_raw = 16'($urandom_range(2));
        end
        partial = ($urandom_range(7) == 0);
        if (partial) h_raw = 16'($urandom_range(7, 65535));
        set_geometry(w_raw, h_raw);
        regeo = 1'b0;
      end
      if (partial) begin
        stream_pixels($urandom_range(1, 3 * w), 10);
        regeo = 1'b1;
      end else begin
        stream_pixels(w * h, 3);
        if ($urandom_range(9) == 0) settle();
        if ($urandom_range(7) == 0) begin
          flush_n($urandom_range(0, w));
        end else begin
          flush_n(w + 1);
          repeat ($urandom_range(2)) begin
            push_item(lef_pkg::REQ_FLUSH, rand_chan(), rand_chan(), rand_chan());
          end
        end
      end
    end

    settle();
    if (fails == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: rgb_laplacian_edge_filter_core.f
hdl/lef_pkg.sv
hdl/lef_pix_if.sv
hdl/lef_res_if.sv
hdl/rgb_laplacian_edge_filter_core.sv
dv/edge_checker.sv
dv/tb.sv
